### src/tlrq_pkg.sv
// Shared types and constants for the three-level ready queue scheduler.
`default_nettype none
package tlrq_pkg;

  // Operation codes carried in the input tuser
  typedef enum logic [2:0] {
    FN_ENQ_READY = 3'd0,
    FN_ENQ_SLEEP = 3'd1,
    FN_DEQUEUE   = 3'd2,
    FN_WAKE      = 3'd3,
    FN_AGE       = 3'd4
  } func_t;

  // Control sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_NEXT  = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_PUSH1 = 7'b0001000,
    S_PUSH2 = 7'b0010000,
    S_SLEEP = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  // Priority levels
  localparam logic [1:0] LVL_HIGH   = 2'd0;
  localparam logic [1:0] LVL_NORMAL = 2'd1;
  localparam logic [1:0] LVL_LOW    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_AGING_THR = 2'd0;
  localparam logic [1:0] CFG_SCAN_PER  = 2'd1;

  // Register reset values
  localparam logic [15:0] AGING_THR_RST = 16'd1000;
  localparam logic [15:0] SCAN_PER_RST  = 16'd50;

  // Level 3 folds onto low
  function automatic logic [1:0] clamp_level(input logic [1:0] p);
    logic [1:0] r;
    r = (p > LVL_LOW) ? LVL_LOW : p;
    return r;
  endfunction

endpackage
`default_nettype wire

### src/tlrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tlrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### src/three_level_ready_queue_with_aging.sv
// Three-level ready queue thread scheduler with sleep list and aging scan.
//
// Input channel (in_*): one beat is one scheduler operation; in_tuser holds the
// operation code, in_tdata the thread, priority, wake time and current time.
// Result channel (out_*): exactly one beat per input beat, in order.
// Config channel (cfg_*): always ready; index 0 aging threshold, 1 scan period.
// Per-thread links, stamps, deadlines and levels live in four small RAMs with
// registered read data; queue heads and tails sit in flops.
// Wake and age walk their lists one node at a time through the link RAM,
// bounded by THREAD_COUNT nodes per list (age walks normal and low); one
// operation is in flight at a time.
// A new beat is taken while the previous result still waits in the output
// register; a stalled receiver holds the next result in the sequencer.
// Reset (synchronous, rst_n low) empties all queues and the sleep list,
// clears the last scan time and loads the register defaults. RAM contents
// are not cleared; entries are always written before a thread is linked.
`default_nettype none
module three_level_ready_queue_with_aging #(
  parameter int THREAD_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: thread_id[5:0], priority_req[7:6], wake_time[39:8], now_ms[71:40]
  input  wire logic [71:0] in_tdata,
  // in_tuser: func[2:0]
  input  wire logic [2:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: picked_thread[5:0], ready_empty[6], zero[7]
  output logic [7:0]       out_tdata,
  // out_tuser: found[0]
  output logic [0:0]       out_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int TW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int CW = $clog2(THREAD_COUNT + 1);

  // Input field split
  logic [5:0]  in_tid;
  logic [1:0]  in_prio;
  logic [31:0] in_wake;
  logic [31:0] in_now;
  assign in_tid  = in_tdata[5:0];
  assign in_prio = in_tdata[7:6];
  assign in_wake = in_tdata[39:8];
  assign in_now  = in_tdata[71:40];

  // Control state
  tlrq_pkg::state_t state_r, state_nxt;
  logic [2:0]  hv_r, hv_nxt, tv_r, tv_nxt;
  logic        sv_r, sv_nxt, cv_r, cv_nxt, pv_r, pv_nxt, nv_r, nv_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [31:0] last_scan_r, last_scan_nxt;
  logic [15:0] thr_r, thr_nxt, per_r, per_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Payload state
  tlrq_pkg::func_t op_r, op_nxt;
  logic [TW-1:0] tid_r, tid_nxt, cur_r, cur_nxt, prev_r, prev_nxt, nx_r, nx_nxt;
  logic [TW-1:0] sh_r, sh_nxt;
  logic [2:0][TW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [1:0]  lvl_r, lvl_nxt, mlvl_r, mlvl_nxt, plvl_r, plvl_nxt;
  logic [31:0] wake_r, wake_nxt, now_r, now_nxt;
  logic [TW-1:0] pick_r, pick_nxt;
  logic        found_r, found_nxt;
  logic [5:0]  out_pick_r, out_pick_nxt;
  logic        out_found_r, out_found_nxt, out_empty_r, out_empty_nxt;

  // RAM ports
  logic          lk_we, st_we, dl_we, lv_we;
  logic [TW-1:0] lk_wa;
  logic [TW:0]   lk_wd, lk_rd;
  logic [31:0]   st_rd, dl_rd;
  logic [1:0]    lv_rd;

  tlrq_ram #(.WIDTH(TW + 1), .DEPTH(THREAD_COUNT)) u_link (
    .clk(clk), .wr_en(lk_we), .wr_addr(lk_wa), .wr_data(lk_wd),
    .rd_addr(cur_r), .rd_data(lk_rd)
  );
  tlrq_ram #(.WIDTH(32), .DEPTH(THREAD_COUNT)) u_stamp (
    .clk(clk), .wr_en(st_we), .wr_addr(cur_r), .wr_data(now_r),
    .rd_addr(cur_r), .rd_data(st_rd)
  );
  tlrq_ram #(.WIDTH(32), .DEPTH(THREAD_COUNT)) u_deadline (
    .clk(clk), .wr_en(dl_we), .wr_addr(tid_r), .wr_data(wake_r),
    .rd_addr(cur_r), .rd_data(dl_rd)
  );
  tlrq_ram #(.WIDTH(2), .DEPTH(THREAD_COUNT)) u_level (
    .clk(clk), .wr_en(lv_we), .wr_addr(cur_r),
    .wr_data((state_r == tlrq_pkg::S_SLEEP) ? lvl_r : mlvl_r),
    .rd_addr(cur_r), .rd_data(lv_rd)
  );

  // Node test for the walk in progress
  logic        tid_ok;
  logic        hit;
  logic [31:0] age_diff;
  assign tid_ok   = 32'(in_tid) < 32'(THREAD_COUNT);
  assign age_diff = now_r - st_rd;
  assign hit = (op_r == tlrq_pkg::FN_WAKE) ? (now_r >= dl_rd)
             : ((st_rd != 32'd0) && (age_diff >= {16'd0, thr_r}));

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    hv_nxt         = hv_r;
    tv_nxt         = tv_r;
    sv_nxt         = sv_r;
    cv_nxt         = cv_r;
    pv_nxt         = pv_r;
    nv_nxt         = nv_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    last_scan_nxt  = last_scan_r;
    thr_nxt        = thr_r;
    per_nxt        = per_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    tid_nxt        = tid_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    nx_nxt         = nx_r;
    sh_nxt         = sh_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    lvl_nxt        = lvl_r;
    mlvl_nxt       = mlvl_r;
    plvl_nxt       = plvl_r;
    wake_nxt       = wake_r;
    now_nxt        = now_r;
    pick_nxt       = pick_r;
    found_nxt      = found_r;
    out_pick_nxt   = out_pick_r;
    out_found_nxt  = out_found_r;
    out_empty_nxt  = out_empty_r;
    lk_we = 1'b0;
    lk_wa = cur_r;
    lk_wd = '0;
    st_we = 1'b0;
    dl_we = 1'b0;
    lv_we = 1'b0;
    in_tready = (state_r == tlrq_pkg::S_IDLE);

    unique case (state_r)
      tlrq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = tlrq_pkg::func_t'(in_tuser);
          tid_nxt   = TW'(in_tid);
          lvl_nxt   = tlrq_pkg::clamp_level(in_prio);
          wake_nxt  = in_wake;
          now_nxt   = in_now;
          pick_nxt  = '0;
          found_nxt = 1'b0;
          pv_nxt    = 1'b0;
          cnt_nxt   = '0;
          state_nxt = tlrq_pkg::S_DONE;
          case (in_tuser)
            tlrq_pkg::FN_ENQ_READY: begin
              if (tid_ok) begin
                cur_nxt   = TW'(in_tid);
                mlvl_nxt  = tlrq_pkg::clamp_level(in_prio);
                state_nxt = tlrq_pkg::S_PUSH1;
              end
            end
            tlrq_pkg::FN_ENQ_SLEEP: begin
              if (tid_ok) begin
                cur_nxt   = TW'(in_tid);
                state_nxt = tlrq_pkg::S_SLEEP;
              end
            end
            tlrq_pkg::FN_DEQUEUE: begin
              if (hv_r[tlrq_pkg::LVL_HIGH]) begin
                plvl_nxt = tlrq_pkg::LVL_HIGH;
              end else if (hv_r[tlrq_pkg::LVL_NORMAL]) begin
                plvl_nxt = tlrq_pkg::LVL_NORMAL;
              end else begin
                plvl_nxt = tlrq_pkg::LVL_LOW;
              end
              cur_nxt = head_r[plvl_nxt];
              cv_nxt  = 1'b1;
              if (hv_r != 3'b000) begin
                state_nxt = tlrq_pkg::S_NEXT;
              end
            end
            tlrq_pkg::FN_WAKE: begin
              cur_nxt   = sh_r;
              cv_nxt    = sv_r;
              state_nxt = tlrq_pkg::S_NEXT;
            end
            tlrq_pkg::FN_AGE: begin
              if ((in_now - last_scan_r) >= {16'd0, per_r}) begin
                last_scan_nxt = in_now;
                plvl_nxt  = tlrq_pkg::LVL_NORMAL;
                cur_nxt   = head_r[tlrq_pkg::LVL_NORMAL];
                cv_nxt    = hv_r[tlrq_pkg::LVL_NORMAL];
                state_nxt = tlrq_pkg::S_NEXT;
              end
            end
            default: state_nxt = tlrq_pkg::S_DONE;
          endcase
        end
      end

      // Launch the read of the current node, move an age scan from normal to low, or close the walk
      tlrq_pkg::S_NEXT: begin
        if (cv_r && (cnt_r < CW'(THREAD_COUNT))) begin
          state_nxt = tlrq_pkg::S_EVAL;
        end else if (op_r == tlrq_pkg::FN_AGE && plvl_r == tlrq_pkg::LVL_NORMAL) begin
          plvl_nxt = tlrq_pkg::LVL_LOW;
          cur_nxt  = head_r[tlrq_pkg::LVL_LOW];
          cv_nxt   = hv_r[tlrq_pkg::LVL_LOW];
          pv_nxt   = 1'b0;
          cnt_nxt  = '0;
        end else begin
          state_nxt = tlrq_pkg::S_DONE;
        end
      end

      // Node data is back: pop, unlink or step on
      tlrq_pkg::S_EVAL: begin
        nx_nxt  = lk_rd[TW-1:0];
        nv_nxt  = lk_rd[TW];
        cnt_nxt = cnt_r + CW'(1);
        if (op_r == tlrq_pkg::FN_DEQUEUE) begin
          head_nxt[plvl_r] = lk_rd[TW-1:0];
          hv_nxt[plvl_r]   = lk_rd[TW];
          if (!lk_rd[TW]) begin
            tv_nxt[plvl_r] = 1'b0;
          end
          pick_nxt  = cur_r;
          found_nxt = 1'b1;
          state_nxt = tlrq_pkg::S_DONE;
        end else if (hit) begin
          if (!pv_r) begin
            if (op_r == tlrq_pkg::FN_WAKE) begin
              sh_nxt = lk_rd[TW-1:0];
              sv_nxt = lk_rd[TW];
            end else begin
              head_nxt[plvl_r] = lk_rd[TW-1:0];
              hv_nxt[plvl_r]   = lk_rd[TW];
            end
          end else begin
            lk_we = 1'b1;
            lk_wa = prev_r;
            lk_wd = lk_rd;
          end
          if (op_r == tlrq_pkg::FN_AGE && tv_r[plvl_r] && tail_r[plvl_r] == cur_r) begin
            tail_nxt[plvl_r] = prev_r;
            tv_nxt[plvl_r]   = pv_r;
          end
          mlvl_nxt = (op_r == tlrq_pkg::FN_WAKE) ? tlrq_pkg::clamp_level(lv_rd)
                                                 : tlrq_pkg::LVL_HIGH;
          state_nxt = tlrq_pkg::S_PUSH1;
        end else begin
          prev_nxt  = cur_r;
          pv_nxt    = 1'b1;
          cur_nxt   = lk_rd[TW-1:0];
          cv_nxt    = lk_rd[TW];
          state_nxt = tlrq_pkg::S_NEXT;
        end
      end

      // Fresh entry: level, stamp, no successor
      tlrq_pkg::S_PUSH1: begin
        lk_we = 1'b1;
        lk_wa = cur_r;
        lk_wd = '0;
        st_we = 1'b1;
        lv_we = 1'b1;
        state_nxt = tlrq_pkg::S_PUSH2;
      end

      // Append at the tail of the target level
      tlrq_pkg::S_PUSH2: begin
        if (tv_r[mlvl_r]) begin
          lk_we = 1'b1;
          lk_wa = tail_r[mlvl_r];
          lk_wd = {1'b1, cur_r};
        end else begin
          head_nxt[mlvl_r] = cur_r;
          hv_nxt[mlvl_r]   = 1'b1;
        end
        tail_nxt[mlvl_r] = cur_r;
        tv_nxt[mlvl_r]   = 1'b1;
        if (op_r == tlrq_pkg::FN_ENQ_READY) begin
          state_nxt = tlrq_pkg::S_DONE;
        end else begin
          cur_nxt   = nx_r;
          cv_nxt    = nv_r;
          state_nxt = tlrq_pkg::S_NEXT;
        end
      end

      // Push onto the front of the sleep list; cur_r holds the thread here
      tlrq_pkg::S_SLEEP: begin
        cur_nxt = tid_r;
        lk_we = 1'b1;
        lk_wa = tid_r;
        lk_wd = {sv_r, sh_r};
        dl_we = 1'b1;
        lv_we = 1'b1;
        sh_nxt = tid_r;
        sv_nxt = 1'b1;
        state_nxt = tlrq_pkg::S_DONE;
      end

      // Hand the result to the output register
      tlrq_pkg::S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_pick_nxt   = 6'(pick_r);
          out_found_nxt  = found_r;
          out_empty_nxt  = (hv_r == 3'b000);
          state_nxt      = tlrq_pkg::S_IDLE;
        end
      end

      default: state_nxt = tlrq_pkg::S_IDLE;
    endcase

    // Configuration writes
    if (cfg_valid) begin
      case (cfg_index)
        tlrq_pkg::CFG_AGING_THR: thr_nxt = cfg_data;
        tlrq_pkg::CFG_SCAN_PER:  per_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tlrq_pkg::S_IDLE;
      hv_r         <= '0;
      tv_r         <= '0;
      sv_r         <= 1'b0;
      cv_r         <= 1'b0;
      pv_r         <= 1'b0;
      nv_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
      last_scan_r  <= '0;
      thr_r        <= tlrq_pkg::AGING_THR_RST;
      per_r        <= tlrq_pkg::SCAN_PER_RST;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      hv_r         <= hv_nxt;
      tv_r         <= tv_nxt;
      sv_r         <= sv_nxt;
      cv_r         <= cv_nxt;
      pv_r         <= pv_nxt;
      nv_r         <= nv_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      last_scan_r  <= last_scan_nxt;
      thr_r        <= thr_nxt;
      per_r        <= per_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    tid_r       <= tid_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    nx_r        <= nx_nxt;
    sh_r        <= sh_nxt;
    head_r      <= head_nxt;
    tail_r      <= tail_nxt;
    lvl_r       <= lvl_nxt;
    mlvl_r      <= mlvl_nxt;
    plvl_r      <= plvl_nxt;
    wake_r      <= wake_nxt;
    now_r       <= now_nxt;
    pick_r      <= pick_nxt;
    found_r     <= found_nxt;
    out_pick_r  <= out_pick_nxt;
    out_found_r <= out_found_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_empty_r, out_pick_r};
  assign out_tuser  = out_found_r;
  assign cfg_ready  = 1'b1;

  // A taken beat closes the input until the operation is finished
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an operation is in flight");

  // A new result appears only from the finishing state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid && !out_tready)) |-> $past(state_r == tlrq_pkg::S_DONE))
    else $error("result loaded outside the finishing state");

  // A list walk never runs past the thread count
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(THREAD_COUNT))
    else $error("list walk exceeded the thread count");

endmodule
`default_nettype wire
